### sv/text_console_cursor_engine_defines.svh
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define TCCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/tcce_pkg.sv
package tcce_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int POS_W  = 11;
  localparam int KIND_W = 2;
  localparam int TGT_W  = 8;
  localparam int TAB_W  = $clog2(TAB_STOP + 1);

  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [ATTR_W-1:0] ATTR_RESET = ATTR_W'(7);

  localparam logic              CMD_PUT = 1'b0;
  localparam logic              CMD_SET = 1'b1;
  localparam logic [CHAR_W-1:0] CH_BS    = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] CH_TAB   = CHAR_W'(9);
  localparam logic [CHAR_W-1:0] CH_NL    = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_CR    = CHAR_W'(13);
  localparam logic [CHAR_W-1:0] CH_SPACE = CHAR_W'(32);

  typedef enum logic [2:0] {
    OP_PUT,
    OP_TAB,
    OP_NL,
    OP_CR,
    OP_BS,
    OP_SET
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_SCROLL = 2'd1,
    KIND_CURSOR = 2'd2
  } kind_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } item_t;

  typedef logic [TAB_W-1:0] tab_tbl_t [2**COL_W];

  function automatic tab_tbl_t build_tab_tbl();
    tab_tbl_t tbl;
    for (int i = 0; i < 2**COL_W; i++) begin
      tbl[i] = TAB_W'(TAB_STOP - (i % TAB_STOP));
    end
    return tbl;
  endfunction

  localparam tab_tbl_t TAB_COUNT = build_tab_tbl();

endpackage

### sv/tcce_front.sv
module tcce_front import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic              cmd_i,
  input  logic [CHAR_W-1:0] char_i,
  input  logic [TGT_W-1:0]  tcol_i,
  input  logic [TGT_W-1:0]  trow_i,
  input  logic              full_i,
  output logic              push_o,
  output item_t             item_o
);

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  item_t item_c;
  logic  keep_c;
  logic  accept;

  always_comb begin
    item_c.op  = OP_PUT;
    item_c.ch  = char_i;
    item_c.col = '0;
    item_c.row = '0;
    keep_c     = 1'b1;
    if (cmd_i == CMD_SET) begin
      item_c.op  = OP_SET;
      item_c.col = tcol_i[COL_W-1:0];
      item_c.row = trow_i[ROW_W-1:0];
      if (tcol_i >= TGT_W'(COLUMNS) || trow_i >= TGT_W'(ROWS)) begin
        keep_c = 1'b0;
      end
    end else begin
      case (char_i)
        CH_BS:   item_c.op = OP_BS;
        CH_TAB:  item_c.op = OP_TAB;
        CH_NL:   item_c.op = OP_NL;
        CH_CR:   item_c.op = OP_CR;
        default: item_c.op = OP_PUT;
      endcase
    end
  end

  assign push_o    = valid_q && !full_i;
  assign s_ready_o = !valid_q || !full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = keep_c;
      item_d  = item_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

### sv/tcce_queue.sv
module tcce_queue import tcce_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### sv/tcce_back.sv
`include "text_console_cursor_engine_defines.svh"

module tcce_back import tcce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [KIND_W-1:0] m_kind_o,
  output logic [COL_W-1:0]  m_col_o,
  output logic [ROW_W-1:0]  m_row_o,
  output logic [CHAR_W-1:0] m_char_o,
  output logic [ATTR_W-1:0] m_attr_o,
  output logic [POS_W-1:0]  m_pos_o,
  output logic              m_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCROLL,
    ST_CURSOR
  } state_e;

  localparam int PROD_W = COL_W + ROW_W;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [CHAR_W-1:0] ch_q, ch_d;
  logic [TAB_W-1:0]  cnt_q, cnt_d;

  logic              m_valid_q, m_valid_d;
  logic [KIND_W-1:0] m_kind_q, m_kind_d;
  logic [COL_W-1:0]  m_col_q, m_col_d;
  logic [ROW_W-1:0]  m_row_q, m_row_d;
  logic [CHAR_W-1:0] m_char_q, m_char_d;
  logic [ATTR_W-1:0] m_attr_q, m_attr_d;
  logic [POS_W-1:0]  m_pos_q, m_pos_d;
  logic              m_last_q, m_last_d;

  logic              out_free;
  logic              do_load;
  logic [PROD_W-1:0] pos_full;
  logic              last_row;

  assign out_free = !m_valid_q || m_ready_i;
  assign do_load  = q_valid_i &&
                    (state_q == ST_IDLE || (state_q == ST_CURSOR && out_free));
  assign q_pop_o  = do_load;
  assign pos_full = PROD_W'(row_q) * PROD_W'(COLUMNS) + PROD_W'(col_q);
  assign last_row = (row_q >= ROW_W'(ROWS - 1));

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    ch_d      = ch_q;
    cnt_d     = cnt_q;
    m_valid_d = out_free ? 1'b0 : m_valid_q;
    m_kind_d  = m_kind_q;
    m_col_d   = m_col_q;
    m_row_d   = m_row_q;
    m_char_d  = m_char_q;
    m_attr_d  = m_attr_q;
    m_pos_d   = m_pos_q;
    m_last_d  = m_last_q;

    if (out_free && state_q != ST_IDLE) begin
      m_valid_d = 1'b1;
      m_col_d   = '0;
      m_row_d   = '0;
      m_char_d  = '0;
      m_attr_d  = '0;
      m_pos_d   = '0;
      m_last_d  = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
      end
      ST_WRITE: begin
        if (out_free) begin
          m_kind_d = KIND_WRITE;
          m_col_d  = col_q;
          m_row_d  = row_q;
          m_char_d = ch_q;
          m_attr_d = attr_i;
          cnt_d    = cnt_q - TAB_W'(1);
          state_d  = (cnt_q == TAB_W'(1)) ? ST_CURSOR : ST_WRITE;
          if (col_q == COL_W'(COLUMNS - 1)) begin
            col_d = '0;
            if (last_row) begin
              row_d   = ROW_W'(ROWS - 1);
              state_d = ST_SCROLL;
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end else begin
            col_d = col_q + COL_W'(1);
          end
        end
      end
      ST_SCROLL: begin
        if (out_free) begin
          m_kind_d = KIND_SCROLL;
          state_d  = (cnt_q != '0) ? ST_WRITE : ST_CURSOR;
        end
      end
      ST_CURSOR: begin
        if (out_free) begin
          m_kind_d = KIND_CURSOR;
          m_pos_d  = pos_full[POS_W-1:0];
          m_last_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_load) begin
      cnt_d   = '0;
      state_d = ST_CURSOR;
      case (q_item_i.op)
        OP_PUT: begin
          ch_d    = q_item_i.ch;
          cnt_d   = TAB_W'(1);
          state_d = ST_WRITE;
        end
        OP_TAB: begin
          ch_d    = CH_SPACE;
          cnt_d   = TAB_COUNT[col_q];
          state_d = ST_WRITE;
        end
        OP_NL: begin
          col_d = '0;
          if (last_row) begin
            row_d   = ROW_W'(ROWS - 1);
            state_d = ST_SCROLL;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end
        OP_BS: begin
          if (col_q == '0) begin
            if (row_q != '0) begin
              row_d = row_q - ROW_W'(1);
              col_d = COL_W'(COLUMNS - 1);
            end
          end else begin
            col_d = col_q - COL_W'(1);
          end
        end
        OP_SET: begin
          col_d = q_item_i.col;
          row_d = q_item_i.row;
        end
        OP_CR: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      ch_q      <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_kind_q  <= KIND_WRITE;
      m_col_q   <= '0;
      m_row_q   <= '0;
      m_char_q  <= '0;
      m_attr_q  <= '0;
      m_pos_q   <= '0;
      m_last_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      ch_q      <= ch_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      m_kind_q  <= m_kind_d;
      m_col_q   <= m_col_d;
      m_row_q   <= m_row_d;
      m_char_q  <= m_char_d;
      m_attr_q  <= m_attr_d;
      m_pos_q   <= m_pos_d;
      m_last_q  <= m_last_d;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = m_kind_q;
  assign m_col_o   = m_col_q;
  assign m_row_o   = m_row_q;
  assign m_char_o  = m_char_q;
  assign m_attr_o  = m_attr_q;
  assign m_pos_o   = m_pos_q;
  assign m_last_o  = m_last_q;

  `TCCE_ASSERT_ALWAYS(a_cursor_on_screen,
    !rst_ni || ((col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS))), "cursor left the screen")
  `TCCE_ASSERT(a_last_only_on_cursor,
    m_valid_q |-> (m_last_q == (m_kind_q == KIND_CURSOR)), "last flag on wrong kind")
  `TCCE_ASSERT(a_pop_when_done,
    q_pop_o |-> (state_q == ST_IDLE || state_q == ST_CURSOR), "pop while item busy")
  `TCCE_ASSERT(a_write_has_count,
    (state_q == ST_WRITE) |-> (cnt_q != '0), "write step with empty count")

endmodule

### sv/text_console_cursor_engine.sv
// Text console cursor engine.
// Input stream (s_axis_*): one transaction per character or set-cursor request.
//   tuser selects the request (put character or set cursor).
// Output stream (m_axis_*): result transactions; tuser gives the kind (cell
//   write, scroll up, cursor update), tlast marks the cursor update that ends
//   the results of one input transaction. Fields a kind does not use are zero.
// Config channel (cfg_*): writes the attribute byte of written cells; always
//   ready, write it while the engine is idle.
// An accepted transaction passes the front register, the queue and the sequencer
//   state before its first result is registered at the output. The back-end
//   sequencer emits one result per cycle while the output is ready and loads the
//   next item in the cycle of the closing cursor update. A printable writes its
//   cell and a tab spaces up to the next tab stop, then a cursor update follows;
//   an off-screen set-cursor request is dropped at the front and yields nothing.
// A two-entry queue parts the front from the back; with the output stalled the
//   front still takes items until the queue and its own register fill.
// Reset puts the cursor at the top left and the attribute at 7, and empties
//   the queue and the output register.
module text_console_cursor_engine import tcce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code, target_col, target_row
  input  logic [0:0]  s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // cell_col, cell_row, cell_char, cell_attr, cursor_pos
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [ATTR_W-1:0] attr_q;
  logic              q_full;
  logic              q_push;
  item_t             q_in;
  logic              q_valid;
  logic              q_pop;
  item_t             q_out;
  logic [COL_W-1:0]  o_col;
  logic [ROW_W-1:0]  o_row;
  logic [CHAR_W-1:0] o_char;
  logic [ATTR_W-1:0] o_attr;
  logic [POS_W-1:0]  o_pos;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_data_i;
    end
  end

  tcce_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser[0]),
    .char_i    (s_axis_tdata[7:0]),
    .tcol_i    (s_axis_tdata[15:8]),
    .trow_i    (s_axis_tdata[23:16]),
    .full_i    (q_full),
    .push_o    (q_push),
    .item_o    (q_in)
  );

  tcce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_out)
  );

  tcce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .attr_i    (attr_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_kind_o  (m_axis_tuser),
    .m_col_o   (o_col),
    .m_row_o   (o_row),
    .m_char_o  (o_char),
    .m_attr_o  (o_attr),
    .m_pos_o   (o_pos),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, o_pos, o_attr, o_char, o_row, o_col};

endmodule
